[sv/assert_macros.svh]
// assertion helpers, clocked on clk with reset arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

[sv/ncvs_pkg.sv]
package ncvs_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int MAX_DIM = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int LEN_W = $clog2(MAX_DIM + 1);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int BOOK_DEPTH = MAX_ENTRIES * MAX_DIM;
	localparam int BOOK_AW = $clog2(BOOK_DEPTH);
	localparam int SQ_W = 32;
	localparam int ACC_W = SQ_W + LEN_W;
	localparam int DIST_W = 36;
	localparam logic [63:0] DIST_MAX = 64'h0000_000F_FFFF_FFFF;
	localparam int QP_W = $clog2(QUEUE_DEPTH);
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 9;
	localparam int VLEN_W = 5;
	localparam int ECNT_W = 9;
	localparam logic [VLEN_W-1:0] VLEN_RESET = 5'd16;
	localparam logic [ECNT_W-1:0] ECNT_RESET = 9'd256;

	localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic operation;
		logic [7:0] entry_index;
		logic [3:0] component_index;
		logic signed [15:0] component_value;
		logic exclude_entry;
		logic last_component;
	} item_t;

	typedef struct packed {
		logic [7:0] nearest_index;
		logic found;
		logic [DIST_W-1:0] best_distance;
	} result_t;

	typedef struct packed {
		logic wr_book;
		logic wr_query;
		logic search;
		logic [EW-1:0] entry;
		logic [CW-1:0] comp;
		logic [15:0] value;
		logic excl;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DRAIN
	} back_state_t;

endpackage

[sv/ncvs_front.sv]
module ncvs_front import ncvs_pkg::*; (
	input logic start,
	input logic full,
	input item_t item,
	output logic push,
	output cmd_t cmd
);

	logic entry_ok;
	logic comp_ok;

	always_comb begin
		entry_ok = 32'(item.entry_index) < 32'(MAX_ENTRIES);
		comp_ok = 32'(item.component_index) < 32'(MAX_DIM);
		cmd.wr_book = (item.operation == OP_LOAD) && entry_ok && comp_ok;
		cmd.wr_query = (item.operation == OP_QUERY) && comp_ok;
		cmd.search = (item.operation == OP_QUERY) && item.last_component;
		cmd.entry = EW'(item.entry_index);
		cmd.comp = CW'(item.component_index);
		cmd.value = item.component_value;
		cmd.excl = item.exclude_entry;
		// out-of-range loads leave nothing to do and are dropped here
		push = start && !full && (cmd.wr_book || cmd.wr_query || cmd.search);
	end

endmodule

[sv/ncvs_queue.sv]
module ncvs_queue import ncvs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t wr_cmd,
	input logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	cmd_t slot_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] cnt_q;

	assign full = (cnt_q == QC_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

[sv/ncvs_back.sv]
`include "assert_macros.svh"

module ncvs_back import ncvs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [VLEN_W-1:0] vector_length,
	input logic [ECNT_W-1:0] entry_count,
	input logic empty,
	input cmd_t head,
	output logic pop,
	output logic done,
	output result_t result
);

	back_state_t state_q;
	back_state_t state_d;

	logic [15:0] cb_mem [BOOK_DEPTH];
	logic excl_mem [MAX_ENTRIES];
	logic [15:0] qbuf_mem [MAX_DIM];

	logic [LEN_W-1:0] len_sat;
	logic [LEN_W-1:0] len_iter;
	logic [CNT_W-1:0] cnt_sat;
	logic issue;
	logic comp_end;
	logic entry_end;
	logic start_search;
	logic emit;
	logic emit_none;
	logic [BOOK_AW-1:0] rd_addr;
	logic [BOOK_AW-1:0] wr_addr;

	logic [EW-1:0] e_q;
	logic [CW-1:0] c_q;

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic [15:0] cb_s1;
	logic [15:0] q_s1;
	logic excl_s1;
	logic excl_s2;
	logic excl_s3;
	logic [EW-1:0] entry_s1;
	logic [EW-1:0] entry_s2;
	logic [EW-1:0] entry_s3;
	logic firstc_s1;
	logic firstc_s2;
	logic firstc_s3;
	logic lastc_s1;
	logic lastc_s2;
	logic lastc_s3;
	logic zero_s1;
	logic [15:0] mag_s2;
	logic [SQ_W-1:0] sq_s3;

	logic signed [16:0] diff;
	logic [16:0] mag_full;
	logic [ACC_W-1:0] acc_sum;
	logic better;

	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] best_q;
	logic [EW-1:0] best_e_q;
	logic found_q;
	logic done_q;
	result_t result_q;

	assign done = done_q;
	assign result = result_q;

	always_comb begin
		len_sat = (32'(vector_length) > 32'(MAX_DIM)) ? LEN_W'(MAX_DIM) : LEN_W'(vector_length);
		cnt_sat = (32'(entry_count) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
			: CNT_W'(entry_count);
		// no components still walks one slot per entry, with the difference forced to zero
		len_iter = (len_sat == '0) ? LEN_W'(1) : len_sat;
		comp_end = (c_q == CW'(len_iter - 1'b1));
		entry_end = (e_q == EW'(cnt_sat - 1'b1));
		rd_addr = BOOK_AW'(e_q) * BOOK_AW'(MAX_DIM) + BOOK_AW'(c_q);
		wr_addr = BOOK_AW'(head.entry) * BOOK_AW'(MAX_DIM) + BOOK_AW'(head.comp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		issue = 1'b0;
		start_search = 1'b0;
		emit = 1'b0;
		emit_none = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if (head.search) begin
						if (cnt_sat == '0) begin
							emit_none = 1'b1;
						end else begin
							start_search = 1'b1;
							state_d = BK_SCAN;
						end
					end
				end
			end
			BK_SCAN: begin
				issue = 1'b1;
				if (comp_end && entry_end) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (!vld_s1 && !vld_s2 && !vld_s3) begin
					emit = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// scan counters, pipeline valids, found flag and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
			c_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			found_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start_search) begin
				e_q <= '0;
				c_q <= '0;
			end else if (issue) begin
				if (comp_end) begin
					c_q <= '0;
					e_q <= e_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (start_search) begin
				found_q <= 1'b0;
			end else if (vld_s3 && lastc_s3 && !excl_s3) begin
				found_q <= 1'b1;
			end
			done_q <= emit || emit_none;
		end
	end

	// codebook, exclude marks and query words
	always_ff @(posedge clk) begin
		if (pop && head.wr_book) begin
			cb_mem[wr_addr] <= head.value;
			excl_mem[head.entry] <= head.excl;
		end
		if (pop && head.wr_query) begin
			qbuf_mem[head.comp] <= head.value;
		end
		cb_s1 <= cb_mem[rd_addr];
		excl_s1 <= excl_mem[e_q];
		q_s1 <= qbuf_mem[c_q];
	end

	always_comb begin
		diff = 17'(signed'(q_s1)) - 17'(signed'(cb_s1));
		mag_full = diff[16] ? 17'(-diff) : 17'(diff);
		acc_sum = (firstc_s3 ? '0 : acc_q) + ACC_W'(sq_s3);
		better = !found_q || (acc_sum < best_q);
	end

	always_ff @(posedge clk) begin
		entry_s1 <= e_q;
		firstc_s1 <= (c_q == '0);
		lastc_s1 <= comp_end;
		zero_s1 <= (len_sat == '0);

		mag_s2 <= zero_s1 ? '0 : mag_full[15:0];
		excl_s2 <= excl_s1;
		entry_s2 <= entry_s1;
		firstc_s2 <= firstc_s1;
		lastc_s2 <= lastc_s1;

		sq_s3 <= SQ_W'(mag_s2) * SQ_W'(mag_s2);
		excl_s3 <= excl_s2;
		entry_s3 <= entry_s2;
		firstc_s3 <= firstc_s2;
		lastc_s3 <= lastc_s2;

		if (vld_s3) begin
			acc_q <= acc_sum;
			if (lastc_s3 && !excl_s3 && better) begin
				best_q <= acc_sum;
				best_e_q <= entry_s3;
			end
		end

		if (emit) begin
			result_q.found <= found_q;
			result_q.nearest_index <= found_q ? 8'(best_e_q) : '0;
			if (!found_q) begin
				result_q.best_distance <= '0;
			end else if (64'(best_q) > DIST_MAX) begin
				result_q.best_distance <= DIST_W'(DIST_MAX);
			end else begin
				result_q.best_distance <= DIST_W'(best_q);
			end
		end else if (emit_none) begin
			result_q <= '0;
		end
	end

	`ASSERT_CLK(a_done_pipe_empty, done_q |-> !vld_s1 && !vld_s2 && !vld_s3, "result before pipeline drained")
	`ASSERT_CLK(a_none_zero, done_q && !result_q.found |-> result_q.best_distance == '0 && result_q.nearest_index == '0, "empty search with nonzero fields")
	`ASSERT_CLK(a_scan_bounds, issue |-> (32'(c_q) < 32'(len_iter)) && (32'(e_q) < 32'(cnt_sat)), "scan counter out of range")
	`ASSERT_NEVER(a_pipe_idle, vld_s3 && state_q == BK_IDLE, "pipeline word in idle")

endmodule

[sv/nearest_codebook_vector_search_unit.sv]
// Nearest codebook vector search: an item is taken when start is high and busy is low; busy
// rises only when the four-word command queue is full. Load words and query words are
// retired one per cycle from the queue outside a search. A query word with last_component
// starts a scan that reads one codebook word per cycle from the codebook RAM, so a search
// reads entry_count * max(vector_length, 1) words, with entry_count clamped to 256 and
// vector_length clamped to 16, then waits for its pipeline to drain; an entry_count of zero
// gives its result without a scan. Items behind a search wait in the queue. The result
// appears on result for one cycle with done high and cannot be held off, so the receiver
// must take it in that cycle.
module nearest_codebook_vector_search_unit import ncvs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input item_t item,
	output logic done,
	output result_t result,
	input logic cfg_write,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	logic [VLEN_W-1:0] vlen_q;
	logic [ECNT_W-1:0] ecnt_q;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	cmd_t push_cmd;
	cmd_t head_cmd;

	assign busy = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= VLEN_RESET;
			ecnt_q <= ECNT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_VECTOR_LENGTH: vlen_q <= cfg_data[VLEN_W-1:0];
				CFG_ENTRY_COUNT: ecnt_q <= cfg_data[ECNT_W-1:0];
				default: ;
			endcase
		end
	end

	ncvs_front u_front (
		.start(start),
		.full(q_full),
		.item(item),
		.push(push),
		.cmd(push_cmd)
	);

	ncvs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_cmd(push_cmd),
		.pop(pop),
		.full(q_full),
		.empty(q_empty),
		.head(head_cmd)
	);

	ncvs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.vector_length(vlen_q),
		.entry_count(ecnt_q),
		.empty(q_empty),
		.head(head_cmd),
		.pop(pop),
		.done(done),
		.result(result)
	);

endmodule

[test/nearest_codebook_vector_search_unit_tb.sv]
module nearest_codebook_vector_search_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ncvs_pkg::*;

	localparam int DRAIN_CYCLES = QUEUE_DEPTH + 20;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int FILL_ENTRIES = 8;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic signed [15:0] book_words [MAX_ENTRIES][MAX_DIM];
	bit skip_mark [MAX_ENTRIES];
	logic signed [15:0] query_words [MAX_DIM];
	logic [VLEN_W-1:0] len_setting;
	logic [ECNT_W-1:0] count_setting;

	result_t nearest_expected [$];
	int failures;
	int stall_cycles;
	int sender_idle_pct;

	nearest_codebook_vector_search_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t nearest_entry();
		int len;
		int cnt;
		int best_e;
		longint sum;
		longint best;
		longint diff;
		bit hit;
		result_t r;
		len = (len_setting > MAX_DIM) ? MAX_DIM : int'(len_setting);
		cnt = (count_setting > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_setting);
		hit = 0;
		best = 0;
		best_e = 0;
		for (int e = 0; e < cnt; e++) begin
			if (!skip_mark[e]) begin
				sum = 0;
				for (int c = 0; c < len; c++) begin
					diff = longint'(query_words[c]) - longint'(book_words[e][c]);
					sum += diff * diff;
				end
				if (!hit || sum < best) begin
					hit = 1;
					best = sum;
					best_e = e;
				end
			end
		end
		if (best > longint'(DIST_MAX))
			best = longint'(DIST_MAX);
		r.found = hit;
		r.nearest_index = hit ? best_e[7:0] : 8'd0;
		r.best_distance = hit ? best[DIST_W-1:0] : '0;
		return r;
	endfunction

	task automatic apply_word(input item_t w);
		if (w.operation == OP_LOAD) begin
			if (int'(w.entry_index) < MAX_ENTRIES && int'(w.component_index) < MAX_DIM) begin
				book_words[w.entry_index][w.component_index] = w.component_value;
				skip_mark[w.entry_index] = w.exclude_entry;
			end
		end else begin
			if (int'(w.component_index) < MAX_DIM)
				query_words[w.component_index] = w.component_value;
			if (w.last_component)
				nearest_expected.push_back(nearest_entry());
		end
	endtask

	function automatic item_t make_word(input logic op, input int entry, input int comp,
			input logic signed [15:0] value, input logic excl, input logic last);
		item_t w;
		w.operation = op;
		w.entry_index = entry[7:0];
		w.component_index = comp[3:0];
		w.component_value = value;
		w.exclude_entry = excl;
		w.last_component = last;
		return w;
	endfunction

	function automatic logic signed [15:0] rand_component();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// called at a falling edge; returns at a falling edge with start still high
	task automatic send_word(input item_t w);
		while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_word(w);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (nearest_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		if (idx == CFG_VECTOR_LENGTH)
			len_setting = val[VLEN_W-1:0];
		else
			count_setting = val[ECNT_W-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_search(input int unsigned len, input int unsigned cnt);
		wait_drained();
		write_reg(CFG_VECTOR_LENGTH, len);
		write_reg(CFG_ENTRY_COUNT, cnt);
	endtask

	// the first FILL_ENTRIES entries get every word, the rest a single word with an exclude mark that stays set
	task automatic fill_codebook();
		sender_idle_pct = 0;
		for (int e = 0; e < MAX_ENTRIES; e++) begin
			if (e < FILL_ENTRIES) begin
				for (int c = 0; c < MAX_DIM; c++) begin
					send_word(make_word(OP_LOAD, e, c, rand_component(),
						(c == MAX_DIM - 1) ? 1'b0 : 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1))));
				end
			end else begin
				send_word(make_word(OP_LOAD, e, $urandom_range(0, MAX_DIM - 1),
					rand_component(), 1'b1, 1'($urandom_range(0, 1))));
			end
		end
		for (int c = 0; c < MAX_DIM; c++)
			send_word(make_word(OP_QUERY, $urandom_range(0, 255), c, rand_component(),
				1'($urandom_range(0, 1)), c == MAX_DIM - 1));
	endtask

	task automatic check_extreme_values();
		set_search(2, 2);
		send_word(make_word(OP_LOAD, 0, 0, 16'sh7fff, 1'b0, 1'b1));
		send_word(make_word(OP_LOAD, 0, 1, 16'sh7fff, 1'b0, 1'b0));
		send_word(make_word(OP_LOAD, 1, 0, 16'sh8000, 1'b1, 1'b0));
		send_word(make_word(OP_LOAD, 1, 1, 16'sh8000, 1'b1, 1'b1));
		send_word(make_word(OP_LOAD, 255, 15, -16'sd1, 1'b1, 1'b0));
		send_word(make_word(OP_QUERY, 255, 0, 16'sh8000, 1'b1, 1'b0));
		send_word(make_word(OP_QUERY, 0, 1, 16'sh8000, 1'b0, 1'b1));
		send_word(make_word(OP_QUERY, 0, 0, 16'sh7fff, 1'b0, 1'b1));
	endtask

	task automatic check_tie_break();
		set_search(2, 2);
		send_word(make_word(OP_LOAD, 1, 0, 16'sh7fff, 1'b0, 1'b0));
		send_word(make_word(OP_LOAD, 1, 1, 16'sh7fff, 1'b0, 1'b0));
		send_word(make_word(OP_QUERY, 0, 0, 16'sd0, 1'b0, 1'b0));
		send_word(make_word(OP_QUERY, 0, 1, 16'sd0, 1'b0, 1'b1));
	endtask

	task automatic check_nothing_found();
		set_search(2, 2);
		send_word(make_word(OP_LOAD, 0, 0, 16'sd100, 1'b1, 1'b0));
		send_word(make_word(OP_LOAD, 1, 1, -16'sd100, 1'b1, 1'b1));
		send_word(make_word(OP_QUERY, 7, 0, 16'sd5, 1'b1, 1'b1));
		set_search(2, 0);
		send_word(make_word(OP_QUERY, 7, 15, 16'sd5, 1'b0, 1'b1));
	endtask

	task automatic check_register_limits();
		set_search(0, 3);
		send_word(make_word(OP_QUERY, 0, 3, rand_component(), 1'b0, 1'b1));
		set_search(31, 511);
		send_word(make_word(OP_QUERY, 0, 15, rand_component(), 1'b0, 1'b1));
		set_search(1, 1);
		send_word(make_word(OP_LOAD, 0, 0, rand_component(), 1'b0, 1'b0));
		send_word(make_word(OP_QUERY, 0, 0, rand_component(), 1'b0, 1'b1));
		set_search(16, 256);
		send_word(make_word(OP_QUERY, 0, 8, rand_component(), 1'b0, 1'b1));
	endtask

	task automatic random_traffic(input int idle_pct);
		int len;
		int cnt;
		int budget;
		int sent;
		int pick;
		int n;
		int s;
		int k;
		int ent;
		sender_idle_pct = idle_pct;
		for (s = 0; s < 2; s++) begin
			pick = $urandom_range(0, 5);
			if (pick == 0) begin
				len = MAX_DIM;
				cnt = MAX_ENTRIES;
				budget = 8;
			end else if (pick == 1) begin
				len = 1;
				cnt = 1;
				budget = 14;
			end else begin
				len = $urandom_range(1, MAX_DIM);
				cnt = $urandom_range(2, 24);
				budget = 14;
			end
			set_search(len, cnt);
			sent = 0;
			while (sent < budget) begin
				pick = $urandom_range(0, 9);
				if (pick < 4) begin
					ent = (pick == 0) ? $urandom_range(0, 255) : $urandom_range(0, cnt - 1);
					// entries past the filled ones keep their exclude mark
					send_word(make_word(OP_LOAD, ent,
						$urandom_range(0, 15), rand_component(),
						(ent >= FILL_ENTRIES) || ($urandom_range(0, 5) == 0),
						1'($urandom_range(0, 1))));
					sent++;
				end else if (pick < 9) begin
					n = $urandom_range(1, len);
					for (k = 0; k < n; k++)
						send_word(make_word(OP_QUERY, $urandom_range(0, 255),
							($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : k,
							rand_component(), 1'($urandom_range(0, 1)), k == n - 1));
					sent += n;
				end else begin
					// stray query word, sequence left open
					send_word(make_word(OP_QUERY, $urandom_range(0, 255), $urandom_range(0, 15),
						rand_component(), 1'($urandom_range(0, 1)), 1'b0));
					sent++;
				end
			end
		end
	endtask

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && done) begin
			if (nearest_expected.size() == 0) begin
				$display("%0t: unexpected result word: expected none, actual %p", $time, result);
				failures++;
			end else begin
				want = nearest_expected.pop_front();
				if (result.nearest_index !== want.nearest_index) begin
					$display("%0t: nearest_index expected %0d actual %0d", $time,
						want.nearest_index, result.nearest_index);
					failures++;
				end
				if (result.found !== want.found) begin
					$display("%0t: found expected %0d actual %0d", $time, want.found,
						result.found);
					failures++;
				end
				if (result.best_distance !== want.best_distance) begin
					$display("%0t: best_distance expected %0d actual %0d", $time,
						want.best_distance, result.best_distance);
					failures++;
				end
			end
		end
		if ((start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("nearest_codebook_vector_search_unit test failed");
			$finish;
		end
	end

	initial begin
		failures = 0;
		stall_cycles = 0;
		sender_idle_pct = 0;
		len_setting = VLEN_RESET;
		count_setting = ECNT_RESET;
		start = 1'b0;
		item = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		fill_codebook();
		check_extreme_values();
		check_tie_break();
		check_nothing_found();
		check_register_limits();
		random_traffic(0);
		random_traffic(80);
		random_traffic(0);
		random_traffic(11);
		wait_drained();

		if (failures == 0)
			$display("nearest_codebook_vector_search_unit test passed");
		else
			$display("nearest_codebook_vector_search_unit test failed");
		$finish;
	end

endmodule
